>>> src/nps3d_pkg.sv
`timescale 1ns / 1ps
package nps3d_pkg;

  localparam int DIST_BITS         = 50;
  localparam int DEF_STORE_DEPTH   = 256;
  localparam int DEF_COORD_BITS    = 24;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } nps3d_state_t;

  typedef struct packed {
    logic start;     // latch query point and count, restart scan address
    logic issue;     // read one store entry this cycle
    logic store_wr;  // write the incoming point into the store
    logic out_load;  // move the best match into the result register
  } nps3d_cmd_t;

  typedef struct packed {
    logic last_addr;  // scan address is at the last entry in use
    logic pipe_busy;  // distance pipeline still holds entries
  } nps3d_sts_t;

endpackage

>>> src/nps3d_ram.sv
`timescale 1ns / 1ps
module nps3d_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/nps3d_dp.sv
`timescale 1ns / 1ps
module nps3d_dp
  import nps3d_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  nps3d_cmd_t                       cmd,
  output nps3d_sts_t                       sts,
  input  logic                             cfg_wr_en,
  input  logic [$clog2(STORE_DEPTH+1)-1:0] cfg_wr_data,
  input  logic signed [COORD_BITS-1:0]     coord_x,
  input  logic signed [COORD_BITS-1:0]     coord_y,
  input  logic signed [COORD_BITS-1:0]     coord_z,
  input  logic [$clog2(STORE_DEPTH)-1:0]   load_index,
  output logic [$clog2(STORE_DEPTH)-1:0]   closest_index,
  output logic [DIST_BITS-1:0]             distance_sq
);

  localparam int IDX_W   = $clog2(STORE_DEPTH);
  localparam int COUNT_W = $clog2(STORE_DEPTH + 1);
  localparam int ABS_W   = COORD_BITS + 1;
  localparam int SQ_W    = 2 * ABS_W;
  localparam int SUM_W   = 2 * COORD_BITS + 2;
  localparam int ENT_W   = 3 * COORD_BITS;

  // configuration and query latch
  logic [COUNT_W-1:0]           count_r, count_nxt;
  logic [IDX_W-1:0]             last_r, last_nxt;
  logic [COUNT_W-1:0]           n_clamp;
  logic signed [COORD_BITS-1:0] qx_r, qy_r, qz_r;
  logic [IDX_W-1:0]             addr_r, addr_nxt;

  // store
  logic             wr_en;
  logic [ENT_W-1:0] wr_data, rd_data;

  // pipeline
  logic                         v1_r, v2_r, v3_r, v4_r;
  logic [IDX_W-1:0]             i1_r, i2_r, i3_r, i4_r;
  logic signed [COORD_BITS-1:0] px, py, pz;
  logic signed [COORD_BITS:0]   dx, dy, dz;
  logic [ABS_W-1:0]             ax_nxt, ay_nxt, az_nxt;
  logic [ABS_W-1:0]             ax_r, ay_r, az_r;
  logic [SQ_W-1:0]              sx_r, sy_r, sz_r;
  logic [SUM_W-1:0]             sum_r;
  logic [SUM_W-1:0]             best_r;
  logic [IDX_W-1:0]             bidx_r;
  logic [DIST_BITS-1:0]         dist_sat;
  logic [IDX_W-1:0]             out_idx_r;
  logic [DIST_BITS-1:0]         out_dist_r;

  always_comb begin
    count_nxt = cfg_wr_en ? cfg_wr_data : count_r;
    if (count_r == '0) begin
      n_clamp = COUNT_W'(1);
    end else if (count_r > COUNT_W'(STORE_DEPTH)) begin
      n_clamp = COUNT_W'(STORE_DEPTH);
    end else begin
      n_clamp = count_r;
    end
    last_nxt = IDX_W'(n_clamp - COUNT_W'(1));
    if (cmd.start) begin
      addr_nxt = '0;
    end else if (cmd.issue) begin
      addr_nxt = addr_r + IDX_W'(1);
    end else begin
      addr_nxt = addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_W'(1);
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    if (cmd.start) begin
      last_r <= last_nxt;
      qx_r   <= coord_x;
      qy_r   <= coord_y;
      qz_r   <= coord_z;
    end
  end

  // loads beyond the store depth are dropped
  assign wr_en   = cmd.store_wr && ({1'b0, load_index} < (IDX_W + 1)'(STORE_DEPTH));
  assign wr_data = {coord_z, coord_y, coord_x};

  nps3d_ram #(
    .WIDTH (ENT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (load_index),
    .wr_data (wr_data),
    .rd_en   (cmd.issue),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  assign px = rd_data[COORD_BITS-1:0];
  assign py = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign pz = rd_data[3*COORD_BITS-1:2*COORD_BITS];

  always_comb begin
    dx = {qx_r[COORD_BITS-1], qx_r} - {px[COORD_BITS-1], px};
    dy = {qy_r[COORD_BITS-1], qy_r} - {py[COORD_BITS-1], py};
    dz = {qz_r[COORD_BITS-1], qz_r} - {pz[COORD_BITS-1], pz};
    ax_nxt = dx[COORD_BITS] ? ABS_W'(-dx) : ABS_W'(dx);
    ay_nxt = dy[COORD_BITS] ? ABS_W'(-dy) : ABS_W'(dy);
    az_nxt = dz[COORD_BITS] ? ABS_W'(-dz) : ABS_W'(dz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    i1_r <= addr_r;
    i2_r <= i1_r;
    i3_r <= i2_r;
    i4_r <= i3_r;
    ax_r <= ax_nxt;
    ay_r <= ay_nxt;
    az_r <= az_nxt;
    sx_r <= ax_r * ax_r;
    sy_r <= ay_r * ay_r;
    sz_r <= az_r * az_r;
    sum_r <= SUM_W'(sx_r) + SUM_W'(sy_r) + SUM_W'(sz_r);
    // strict less keeps the lower index on ties; entry zero always seeds
    if (v4_r && (i4_r == '0 || sum_r < best_r)) begin
      best_r <= sum_r;
      bidx_r <= i4_r;
    end
    if (cmd.out_load) begin
      out_idx_r  <= bidx_r;
      out_dist_r <= dist_sat;
    end
  end

  generate
    if (SUM_W > DIST_BITS) begin : g_sat
      assign dist_sat = (|best_r[SUM_W-1:DIST_BITS]) ? '1 : best_r[DIST_BITS-1:0];
    end else begin : g_ext
      assign dist_sat = DIST_BITS'(best_r);
    end
  endgenerate

  assign sts.last_addr = (addr_r == last_r);
  assign sts.pipe_busy = v1_r | v2_r | v3_r | v4_r;

  assign closest_index = out_idx_r;
  assign distance_sq   = out_dist_r;

endmodule

>>> src/nps3d_ctrl.sv
`timescale 1ns / 1ps
module nps3d_ctrl
  import nps3d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_func,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output nps3d_cmd_t cmd,
  input  nps3d_sts_t sts
);

  nps3d_state_t state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == FUNC_QUERY) begin
            cmd.start = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            cmd.store_wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.last_addr) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // wait here while an earlier result is still unread
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> src/nearest_point_search_3d.sv
`timescale 1ns / 1ps
// channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready   | tuser: func; tdata: coord_x, coord_y, coord_z, load_index
// out_    | out | out_tvalid/out_tready | tdata: closest_index, distance_sq
// cfg_    | in  | cfg_wr_en             | cfg_wr_data: point_count
//
// a load item is written into the store as it is taken; a query item scans one store
// entry per cycle through the single read port of the point store, and each entry
// then passes the read, difference, square, sum and compare stages
// reset sets point_count to 1; store contents are undefined until loaded
// the result register holds while out_tready is low; new items are taken meanwhile,
// and a following query waits after its scan until that register is free
module nearest_point_search_3d
  import nps3d_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // coord_x, coord_y, coord_z, load_index, zero pad
  input  logic [((3*COORD_BITS+$clog2(STORE_DEPTH)+7)/8)*8-1:0] in_tdata,
  // func
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // closest_index, distance_sq, zero pad
  output logic [(($clog2(STORE_DEPTH)+DIST_BITS+7)/8)*8-1:0] out_tdata,
  input  logic cfg_wr_en,
  input  logic [$clog2(STORE_DEPTH+1)-1:0] cfg_wr_data
);

  localparam int IDX_W  = $clog2(STORE_DEPTH);
  localparam int OUT_DW = ((IDX_W + DIST_BITS + 7) / 8) * 8;

  nps3d_cmd_t           cmd;
  nps3d_sts_t           sts;
  logic [IDX_W-1:0]     closest_index;
  logic [DIST_BITS-1:0] distance_sq;

  nps3d_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_func   (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  nps3d_dp #(
    .STORE_DEPTH (STORE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .coord_x       (in_tdata[COORD_BITS-1:0]),
    .coord_y       (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .coord_z       (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .load_index    (in_tdata[3*COORD_BITS+IDX_W-1:3*COORD_BITS]),
    .closest_index (closest_index),
    .distance_sq   (distance_sq)
  );

  assign out_tdata = OUT_DW'({distance_sq, closest_index});

  // the pipeline is empty whenever a new item can be taken
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !sts.pipe_busy)
    else $error("distance pipeline busy while accepting items");

  // no store read while an item may be accepted
  a_no_issue_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !in_tready)
    else $error("scan read issued in idle state");

  // the result register is loaded only after the last entry has been compared
  a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.pipe_busy && !cmd.issue)
    else $error("result loaded before scan finished");

  // a loaded result is presented in the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("loaded result not presented");

endmodule
